[sv/rg2d_pkg.sv]
// ----------------------------------------------------------------------------
// rg2d_pkg
// Shared types, register codes and the exponent fraction table for the
// rotated elliptical gaussian evaluator.
// ----------------------------------------------------------------------------
package rg2d_pkg;

    localparam int EXP_TABLE_BITS = 8;
    localparam int TAB_SIZE       = 1 << EXP_TABLE_BITS;
    localparam int NUM_STAGES     = 11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] LOG2E_HALF_Q16 = 16'd47274;
    localparam logic [24:0] CLAMP_Q16      = 25'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTRE_X     = 3'd0,
        REG_CENTRE_Y     = 3'd1,
        REG_COS_ROTATION = 3'd2,
        REG_SIN_ROTATION = 3'd3,
        REG_INV_SIGMA_X  = 3'd4,
        REG_INV_SIGMA_Y  = 3'd5,
        REG_PEAK_VALUE   = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [19:0] centre_x;
        logic signed [19:0] centre_y;
        logic signed [15:0] cos_rotation;
        logic signed [15:0] sin_rotation;
        logic        [19:0] inv_sigma_x;
        logic        [19:0] inv_sigma_y;
        logic        [31:0] peak_value;
    } t_cfg;

    typedef logic [31:0] t_tab [TAB_SIZE];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // q.31 entries, tab[k] ~ 2^(-k / TAB_SIZE)
    function automatic t_tab build_exp_tab();
        logic [63:0] f [EXP_TABLE_BITS];
        logic [63:0] v;
        logic [63:0] acc;
        t_tab        tab;
        v = 64'd1 << 30;
        for (int j = EXP_TABLE_BITS - 1; j >= 0; j--) begin
            v = isqrt64(v << 31);
            f[j] = v;
        end
        for (int k = 0; k < TAB_SIZE; k++) begin
            acc = 64'd1 << 31;
            for (int j = 0; j < EXP_TABLE_BITS; j++) begin
                if (((k >> j) & 1) != 0) begin
                    acc = (acc * f[j] + (64'd1 << 30)) >> 31;
                end
            end
            tab[k] = acc[31:0];
        end
        return tab;
    endfunction

    localparam t_tab EXP_TAB = build_exp_tab();

endpackage

[sv/rg2d_cfg.sv]
// ----------------------------------------------------------------------------
// rg2d_cfg
// Configuration register bank, written through an index and data channel.
// ----------------------------------------------------------------------------
module rg2d_cfg
    import rg2d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CENTRE_X:     n_cfg.centre_x     = i_cfg_data[19:0];
                REG_CENTRE_Y:     n_cfg.centre_y     = i_cfg_data[19:0];
                REG_COS_ROTATION: n_cfg.cos_rotation = i_cfg_data[15:0];
                REG_SIN_ROTATION: n_cfg.sin_rotation = i_cfg_data[15:0];
                REG_INV_SIGMA_X:  n_cfg.inv_sigma_x  = i_cfg_data[19:0];
                REG_INV_SIGMA_Y:  n_cfg.inv_sigma_y  = i_cfg_data[19:0];
                REG_PEAK_VALUE:   n_cfg.peak_value   = i_cfg_data[31:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_x     <= '0;
            r_cfg.centre_y     <= '0;
            r_cfg.cos_rotation <= 16'sd16384;
            r_cfg.sin_rotation <= '0;
            r_cfg.inv_sigma_x  <= 20'd65536;
            r_cfg.inv_sigma_y  <= 20'd65536;
            r_cfg.peak_value   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[sv/rotated_gaussian_2d_eval.sv]
// ----------------------------------------------------------------------------
// rotated_gaussian_2d_eval
// Rotated elliptical 2D gaussian, density = peak * 2^-(chi2 * log2(e) / 2).
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------
//   point    | in        | i_valid / o_stall      | i_point_x, i_point_y
//   density  | out       | o_valid / i_stall      | o_density
//   config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One point per cycle while the output is not stalled; each point passes through every stage in order.
// Each stage holds a valid bit; empty stages keep loading while the output
// is stalled, so stall reaches the input only once every stage is full.
// Synchronous reset empties the pipe and loads the register defaults.
// Config writes are taken every cycle (ready is always high).
// ----------------------------------------------------------------------------
module rotated_gaussian_2d_eval
    import rg2d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [19:0]    i_point_x,
    input  logic signed [19:0]    i_point_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_density,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    rg2d_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // stage control
    logic [NUM_STAGES:1] r_vld;
    logic [NUM_STAGES:1] ce;

    always_comb begin
        ce[NUM_STAGES] = !r_vld[NUM_STAGES] || !i_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            ce[k] = !r_vld[k] || ce[k+1];
        end
    end

    assign o_stall = !ce[1];
    assign o_valid = r_vld[NUM_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ce[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (ce[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: offsets from centre
    logic signed [20:0] r_dx, r_dy;
    logic signed [20:0] n_dx, n_dy;
    assign n_dx = 21'(i_point_x) - 21'(cfg.centre_x);
    assign n_dy = 21'(i_point_y) - 21'(cfg.centre_y);

    // stage 2: rotation products
    logic signed [36:0] r_cdx, r_sdy, r_cdy, r_sdx;
    logic signed [36:0] n_cdx, n_sdy, n_cdy, n_sdx;
    assign n_cdx = 37'(cfg.cos_rotation) * 37'(r_dx);
    assign n_sdy = 37'(cfg.sin_rotation) * 37'(r_dy);
    assign n_cdy = 37'(cfg.cos_rotation) * 37'(r_dy);
    assign n_sdx = 37'(cfg.sin_rotation) * 37'(r_dx);

    // stage 3: rotated coordinates, magnitude only
    logic signed [37:0] xr, yr;
    logic        [37:0] xr_abs, yr_abs;
    logic        [36:0] r_magx, r_magy;
    assign xr     = 38'(r_cdx) + 38'(r_sdy);
    assign yr     = 38'(r_cdy) - 38'(r_sdx);
    assign xr_abs = xr[37] ? 38'(-xr) : 38'(xr);
    assign yr_abs = yr[37] ? 38'(-yr) : 38'(yr);

    // stage 4: scale by inverse sigma
    logic [56:0] r_px, r_py;
    logic [56:0] n_px, n_py;
    assign n_px = 57'(r_magx) * 57'(cfg.inv_sigma_x);
    assign n_py = 57'(r_magy) * 57'(cfg.inv_sigma_y);

    // stage 5: round to q.16 and clamp
    logic [57:0] px_rnd, py_rnd;
    logic [35:0] ax_full, ay_full;
    logic [24:0] r_ax, r_ay;
    logic [24:0] n_ax, n_ay;
    assign px_rnd  = 58'(r_px) + (58'd1 << 21);
    assign py_rnd  = 58'(r_py) + (58'd1 << 21);
    assign ax_full = px_rnd[57:22];
    assign ay_full = py_rnd[57:22];
    assign n_ax    = (ax_full > 36'(CLAMP_Q16)) ? CLAMP_Q16 : ax_full[24:0];
    assign n_ay    = (ay_full > 36'(CLAMP_Q16)) ? CLAMP_Q16 : ay_full[24:0];

    // stage 6: squares
    logic [49:0] r_sqx, r_sqy;
    logic [49:0] n_sqx, n_sqy;
    assign n_sqx = 50'(r_ax) * 50'(r_ax);
    assign n_sqy = 50'(r_ay) * 50'(r_ay);

    // stage 7: chi squared, q.16
    logic [50:0] sqx_rnd, sqy_rnd;
    logic [33:0] r_chi2;
    logic [33:0] n_chi2;
    assign sqx_rnd = 51'(r_sqx) + (51'd1 << 15);
    assign sqy_rnd = 51'(r_sqy) + (51'd1 << 15);
    assign n_chi2  = 34'(sqx_rnd[50:16]) + 34'(sqy_rnd[50:16]);

    // stage 8: exponent in q.32, split into shift and table index
    logic [49:0]               t_exp;
    logic                      r_far8;
    logic [4:0]                r_n8;
    logic [EXP_TABLE_BITS-1:0] r_idx;
    assign t_exp = 50'(r_chi2) * 50'(LOG2E_HALF_Q16);

    // stage 9: fraction lookup
    logic        r_far9;
    logic [4:0]  r_n9;
    logic [31:0] r_tab;

    // stage 10: peak times fraction
    logic        r_far10;
    logic [4:0]  r_n10;
    logic [63:0] r_prod;
    logic [63:0] n_prod;
    assign n_prod = 64'(cfg.peak_value) * 64'(r_tab);

    // stage 11: integer part shift, zero for far tail or bad sigma
    logic [5:0]  shamt;
    logic [63:0] shifted;
    logic        sigma_bad;
    logic [31:0] r_density;
    logic [31:0] n_density;
    assign shamt     = 6'd31 + 6'(r_n10);
    assign shifted   = r_prod >> shamt;
    assign sigma_bad = (cfg.inv_sigma_x == '0) || (cfg.inv_sigma_y == '0);
    assign n_density = (r_far10 || sigma_bad) ? '0 : shifted[31:0];
    assign o_density = r_density;

    always_ff @(posedge i_clk) begin
        if (ce[1]) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (ce[2]) begin
            r_cdx <= n_cdx;
            r_sdy <= n_sdy;
            r_cdy <= n_cdy;
            r_sdx <= n_sdx;
        end
        if (ce[3]) begin
            r_magx <= xr_abs[36:0];
            r_magy <= yr_abs[36:0];
        end
        if (ce[4]) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (ce[5]) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
        end
        if (ce[6]) begin
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
        end
        if (ce[7]) begin
            r_chi2 <= n_chi2;
        end
        if (ce[8]) begin
            r_far8 <= |t_exp[49:37];
            r_n8   <= t_exp[36:32];
            r_idx  <= t_exp[31 -: EXP_TABLE_BITS];
        end
        if (ce[9]) begin
            r_far9 <= r_far8;
            r_n9   <= r_n8;
            r_tab  <= EXP_TAB[r_idx];
        end
        if (ce[10]) begin
            r_far10 <= r_far9;
            r_n10   <= r_n9;
            r_prod  <= n_prod;
        end
        if (ce[11]) begin
            r_density <= n_density;
        end
    end

endmodule

[sv/rg2d_checker.sv]
// ----------------------------------------------------------------------------
// rg2d_checker
// Port level checks for the gaussian evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rg2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        i_stall,
    input logic        o_valid,
    input logic [31:0] o_density
);

    // backpressure at the input only comes from the output side
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled while output is not stalled");

    // a result held by the receiver stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_density)))
        else $error("stalled result changed or dropped");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // nothing can be stalled at the input straight after reset
    a_reset_no_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind rotated_gaussian_2d_eval rg2d_checker u_rg2d_checker (.*);

[tb/tb_rotated_gaussian_2d_eval.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotated_gaussian_2d_eval
// Streams points through the rotated gaussian evaluator under random idling
// on both channels. Every density is checked against a bit-exact predictor
// that keeps its own copy of the registers and of the exponent table.
// ----------------------------------------------------------------------------
module tb_rotated_gaussian_2d_eval;
    import rg2d_pkg::*;

    localparam int                   CLK_HALF       = 5;
    localparam int                   RESET_CYCLES   = 4;
    localparam int                   END_WAIT       = 3 * NUM_STAGES;
    localparam int                   WATCHDOG_LIMIT = 5000;
    localparam int                   PHASE_POINTS   = 100;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic signed [19:0]    i_point_x   = '0;
    logic signed [19:0]    i_point_y   = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [31:0]           o_density;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register image as the block should hold it
    logic signed [19:0] gauss_centre_x = '0;
    logic signed [19:0] gauss_centre_y = '0;
    logic signed [15:0] gauss_cos      = 16'sd16384;
    logic signed [15:0] gauss_sin      = '0;
    logic        [19:0] gauss_inv_sx   = 20'd65536;
    logic        [19:0] gauss_inv_sy   = 20'd65536;
    logic        [31:0] gauss_peak     = '0;

    logic [63:0] exp_frac_tab [TAB_SIZE];
    logic [31:0] expected_density_q [$];
    logic [31:0] want_density;
    int          fail_count     = 0;
    int          idle_cycles    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    rotated_gaussian_2d_eval u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_density   (o_density),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] floor_sqrt64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // q.31 fractions of 2^(-k/TAB_SIZE), built from repeated square roots of 1/2
    function automatic void fill_exp_table();
        logic [63:0] halving [EXP_TABLE_BITS];
        logic [63:0] v;
        logic [63:0] acc;
        v = 64'd1 << 30;
        for (int j = EXP_TABLE_BITS - 1; j >= 0; j--) begin
            v = floor_sqrt64(v << 31);
            halving[j] = v;
        end
        for (int k = 0; k < TAB_SIZE; k++) begin
            acc = 64'd1 << 31;
            for (int j = 0; j < EXP_TABLE_BITS; j++) begin
                if (k[j]) begin
                    acc = (acc * halving[j] + (64'd1 << 30)) >> 31;
                end
            end
            exp_frac_tab[k] = acc;
        end
    endfunction

    // |r| * inv_sigma from q.38 down to q.16, rounded, clamped
    function automatic logic [63:0] scaled_offset(input longint r, input logic [19:0] inv);
        logic [63:0] mag;
        logic [63:0] a;
        mag = (r < 0) ? -r : r;
        a = (mag * {44'd0, inv} + (64'd1 << 21)) >> 22;
        if (a > {39'd0, CLAMP_Q16}) begin
            a = {39'd0, CLAMP_Q16};
        end
        return a;
    endfunction

    function automatic logic [31:0] predict_density(input logic [19:0] px,
                                                    input logic [19:0] py);
        longint      dx;
        longint      dy;
        longint      xr;
        longint      yr;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] chi2;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] prod;
        if (gauss_inv_sx == '0 || gauss_inv_sy == '0) begin
            return '0;
        end
        dx = longint'($signed(px)) - longint'(gauss_centre_x);
        dy = longint'($signed(py)) - longint'(gauss_centre_y);
        xr = longint'(gauss_cos) * dx + longint'(gauss_sin) * dy;
        yr = longint'(gauss_cos) * dy - longint'(gauss_sin) * dx;
        ax = scaled_offset(xr, gauss_inv_sx);
        ay = scaled_offset(yr, gauss_inv_sy);
        chi2 = ((ax * ax + (64'd1 << 15)) >> 16) + ((ay * ay + (64'd1 << 15)) >> 16);
        t = chi2 * {48'd0, LOG2E_HALF_Q16};
        n = t >> 32;
        if (n >= 64'd32) begin
            return '0;
        end
        prod = {32'd0, gauss_peak} * exp_frac_tab[t[31 -: EXP_TABLE_BITS]];
        prod = prod >> (64'd31 + n);
        return prod[31:0];
    endfunction

    // ------------------------------------------------------------------
    // result checking and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_density_q.size() == 0) begin
                $error("density: unexpected transaction, actual %h", o_density);
                fail_count++;
            end else begin
                want_density = expected_density_q.pop_front();
                if (o_density !== want_density) begin
                    $error("density mismatch: expected %h actual %h",
                           want_density, o_density);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rotated_gaussian_2d_eval verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------
    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic send_point(input logic [19:0] px, input logic [19:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        do @(posedge i_clk); while (o_stall);
        expected_density_q.push_back(predict_density(px, py));
    endtask

    // sender holds off until the pipe is empty
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (expected_density_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CENTRE_X:     gauss_centre_x = data[19:0];
            REG_CENTRE_Y:     gauss_centre_y = data[19:0];
            REG_COS_ROTATION: gauss_cos      = data[15:0];
            REG_SIN_ROTATION: gauss_sin      = data[15:0];
            REG_INV_SIGMA_X:  gauss_inv_sx   = data[19:0];
            REG_INV_SIGMA_Y:  gauss_inv_sy   = data[19:0];
            REG_PEAK_VALUE:   gauss_peak     = data[31:0];
            default: ;
        endcase
    endtask

    task automatic end_reg_writes();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_shape(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] c, input logic [31:0] s,
                               input logic [31:0] isx, input logic [31:0] isy,
                               input logic [31:0] peak);
        wait_for_drain();
        write_reg(REG_CENTRE_X, cx);
        write_reg(REG_CENTRE_Y, cy);
        write_reg(REG_COS_ROTATION, c);
        write_reg(REG_SIN_ROTATION, s);
        write_reg(REG_INV_SIGMA_X, isx);
        write_reg(REG_INV_SIGMA_Y, isy);
        write_reg(REG_PEAK_VALUE, peak);
        end_reg_writes();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // zero peak out of reset, then unit peak over the other reset values
    task automatic test_reset_defaults();
        send_point(20'd0, 20'd0);
        send_point(20'd100, 20'hFFF9C);
        wait_for_drain();
        write_reg(REG_PEAK_VALUE, 32'h0001_0000);
        end_reg_writes();
        send_point(20'd0, 20'd0);
        send_point(20'h00100, 20'd0);
    endtask

    task automatic test_field_extremes();
        write_shape(32'd0, 32'd0, 32'd16384, 32'd0, 32'd65536, 32'd65536, 32'hFFFF_FFFF);
        send_point(20'd0, 20'd0);
        send_point(20'h80000, 20'h80000);
        send_point(20'h7FFFF, 20'h7FFFF);
        send_point(20'h80000, 20'h7FFFF);
        send_point(20'd1, 20'hFFFFF);
        send_point(20'hFFF00, 20'h00100);
        // largest inverse sigma: a small offset, then offsets that saturate the clamp
        write_shape(32'd0, 32'd0, 32'd16384, 32'd0, 32'hF_FFFF, 32'hF_FFFF, 32'hFFFF_FFFF);
        send_point(20'd1, 20'd0);
        send_point(20'h7FFFF, 20'h80000);
    endtask

    // exponent integer part just below and just at 32
    task automatic test_far_tail();
        write_shape(32'd0, 32'd0, 32'd16384, 32'd0, 32'd65536, 32'd65536, 32'hFFFF_FFFF);
        send_point(20'd1705, 20'd0);
        send_point(20'd1706, 20'd0);
    endtask

    task automatic test_invalid_sigma();
        wait_for_drain();
        write_reg(REG_INV_SIGMA_X, 32'd0);
        end_reg_writes();
        send_point(20'd0, 20'd0);
        wait_for_drain();
        write_reg(REG_INV_SIGMA_X, 32'd65536);
        write_reg(REG_INV_SIGMA_Y, 32'd0);
        end_reg_writes();
        send_point(20'd0, 20'd0);
    endtask

    task automatic test_rotation_and_centre();
        // extreme centre, upper data bits beyond the register width
        write_shape(32'hFFF8_0000, 32'h0007_FFFF, 32'hFFFF_C000, 32'd0,
                    32'd65536, 32'd32768, 32'h8000_0000);
        send_point(20'h80000, 20'h7FFFF);
        send_point(20'h80100, 20'h7FEFF);
        write_shape(32'd0, 32'd0, 32'd0, 32'd16384, 32'd65536, 32'd131072, 32'h0100_0000);
        send_point(20'h00100, 20'h00080);
        send_point(20'hFFE00, 20'h00040);
        write_shape(32'd256, 32'hFFFF_FF00, 32'd0, 32'hFFFF_C000,
                    32'd40000, 32'd90000, 32'h0001_0000);
        send_point(20'h00180, 20'hFFF80);
        // patterns beyond a unit rotation, plus a write to a missing index
        write_shape(32'd0, 32'd0, 32'h0000_7FFF, 32'hFFFF_8000,
                    32'd4096, 32'd4096, 32'h7FFF_FFFF);
        send_point(20'h00010, 20'hFFFF0);
        wait_for_drain();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        end_reg_writes();
        send_point(20'h00200, 20'h00100);
    endtask

    task automatic load_random_shape(input bit raw, output int span);
        int          c;
        int          s;
        int          e;
        logic [31:0] isx;
        logic [31:0] isy;
        if (raw) begin
            isx  = $urandom();
            isy  = $urandom();
            write_shape($urandom(), $urandom(), $urandom(), $urandom(), isx, isy, $urandom());
            span = 1 << 18;
        end else begin
            c = int'($urandom_range(32768)) - 16384;
            s = int'($sqrt(real'(16384 * 16384 - c * c)));
            if ($urandom_range(1)) begin
                s = -s;
            end
            e   = int'($urandom_range(19, 10));
            isx = $urandom_range((1 << e) - 1, 1 << (e - 1));
            isy = $urandom_range((1 << e) - 1, 1 << (e - 2));
            span = (1 << 27) / int'(isx);
            write_shape($urandom(), $urandom(), c, s, isx, isy, $urandom());
        end
    endtask

    // mostly points near the centre so the exponent path is exercised
    task automatic test_random_stream();
        int          span;
        logic [19:0] px;
        logic [19:0] py;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                set_idling(22, 73);
            end else if (phase < 4) begin
                set_idling(73, 22);
            end else begin
                set_idling(0, 0);
            end
            load_random_shape(phase == 3, span);
            for (int k = 0; k < PHASE_POINTS; k++) begin
                if ($urandom_range(99) < 80) begin
                    px = 20'(int'(gauss_centre_x) + int'($urandom_range(2 * span)) - span);
                    py = 20'(int'(gauss_centre_y) + int'($urandom_range(2 * span)) - span);
                end else begin
                    px = 20'($urandom());
                    py = 20'($urandom());
                end
                send_point(px, py);
                if (phase == 1 && k == PHASE_POINTS / 2) begin
                    wait_for_drain();
                end
            end
        end
    endtask

    initial begin
        fill_exp_table();
        set_idling(22, 73);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_far_tail();
        test_invalid_sigma();
        test_rotation_and_centre();
        test_random_stream();

        wait_for_drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (expected_density_q.size() != 0) begin
            $error("density: %0d transactions never arrived", expected_density_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("rotated_gaussian_2d_eval verification clean");
        end else begin
            $display("rotated_gaussian_2d_eval verification failed");
        end
        $finish;
    end

endmodule
